@@ sv/bdhe_pkg.sv @@
// shared types and constants for the button debouncer with hold events
package bdhe_pkg;

   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CLEAR_W     = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = COUNT_W'(50);
   localparam logic [COUNT_W-1:0] HOLD_RESET     = COUNT_W'(500);

   // bit positions within the clear mask
   localparam int unsigned CLR_PRESS   = 0;
   localparam int unsigned CLR_HOLD    = 1;
   localparam int unsigned CLR_RELEASE = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE = 8'd0,
      CSR_HOLD     = 8'd1
   } csr_index_type;

   // button status kept between ticks
   typedef struct packed {
      logic ev_hold;
      logic held;
      logic ev_release;
      logic ev_press;
      logic was_pressed;
      logic pressed;
   } status_type;

   // one result
   typedef struct packed {
      logic is_pressed;
      logic is_held;
      logic press_event;
      logic hold_event;
      logic release_event;
   } result_type;

endpackage

@@ sv/bdhe_step.sv @@
// per-tick status update: counter, debounce sampling, edge and hold detection
module bdhe_step (
   input  bdhe_pkg::status_type                  status,
   input  logic [bdhe_pkg::COUNT_W-1:0]          count,
   input  logic                                  pin_level,
   input  logic [bdhe_pkg::CLEAR_W-1:0]          clear_events,
   input  logic [bdhe_pkg::COUNT_W-1:0]          debounce_ms,
   input  logic [bdhe_pkg::COUNT_W-1:0]          hold_ms,
   output bdhe_pkg::status_type                  status_next,
   output logic [bdhe_pkg::COUNT_W-1:0]          count_next,
   output bdhe_pkg::result_type                  result
);
   import bdhe_pkg::*;

   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] elapsed;
   logic               pressed_smp;
   status_type         upd;

   always_comb begin
      // saturating tick counter
      count_inc   = (count != COUNT_MAX) ? count + COUNT_W'(1) : count;
      pressed_smp = (count_inc > debounce_ms) ? ~pin_level : status.pressed;

      upd         = status;
      upd.pressed = pressed_smp;
      count_next  = count_inc;
      elapsed     = count_inc;

      if (status.was_pressed && !pressed_smp) begin
         // release clears everything but the release event
         upd            = '0;
         upd.ev_release = 1'b1;
         count_next     = '0;
      end else if (!status.was_pressed && pressed_smp) begin
         upd             = '0;
         upd.pressed     = 1'b1;
         upd.was_pressed = 1'b1;
         upd.ev_press    = 1'b1;
         count_next      = '0;
         elapsed         = '0;
      end

      if (upd.pressed && !upd.held && (elapsed >= hold_ms)) begin
         upd.held    = 1'b1;
         upd.ev_hold = 1'b1;
      end

      result.is_pressed    = upd.pressed;
      result.is_held       = upd.held;
      result.press_event   = upd.ev_press;
      result.hold_event    = upd.ev_hold;
      result.release_event = upd.ev_release;

      status_next = upd;
      if (clear_events[CLR_PRESS]) begin
         status_next.ev_press = 1'b0;
      end
      if (clear_events[CLR_HOLD]) begin
         status_next.ev_hold = 1'b0;
      end
      if (clear_events[CLR_RELEASE]) begin
         status_next.ev_release = 1'b0;
      end
   end

endmodule

@@ sv/button_debounce_hold_events.sv @@
// top level of the button debouncer with press, hold and release events
// Each request is one millisecond tick carrying the raw active-low pin level
// and a mask of latched events to clear after they are reported. The block
// takes one request per clock while req_stall is low and returns exactly one
// response per request. The request lands in an input register, the status
// update (saturating counter, debounce sampling, edge and hold checks) is one
// pass of logic, and the response sits in an output register. While a
// response is stalled, one more request is still taken into the input
// register. csr_ready is always high; register 0 is the debounce time,
// register 1 the hold time, other indexes are ignored. Write them only while
// no request is in flight.
module button_debounce_hold_events (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_pin_level,
   input  logic [bdhe_pkg::CLEAR_W-1:0]          req_clear_events,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_is_pressed,
   output logic                                  rsp_is_held,
   output logic                                  rsp_press_event,
   output logic                                  rsp_hold_event,
   output logic                                  rsp_release_event,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bdhe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bdhe_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bdhe_pkg::*;

   // configuration registers
   logic [COUNT_W-1:0] debounce_ff, debounce_in;
   logic [COUNT_W-1:0] hold_ff, hold_in;

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic               in_level_ff, in_level_in;
   logic [CLEAR_W-1:0] in_clear_ff, in_clear_in;

   // button state
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // output stage
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   status_type         status_next;
   logic [COUNT_W-1:0] count_next;
   result_type         result;
   logic               advance;
   logic               req_take;

   bdhe_step u_step (
      .status       (status_ff),
      .count        (count_ff),
      .pin_level    (in_level_ff),
      .clear_events (in_clear_ff),
      .debounce_ms  (debounce_ff),
      .hold_ms      (hold_ff),
      .status_next  (status_next),
      .count_next   (count_next),
      .result       (result)
   );

   // input register moves on when the output register is empty or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: debounce_in = csr_data[COUNT_W-1:0];
            CSR_HOLD:     hold_in     = csr_data[COUNT_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_level_in = req_take ? req_pin_level : in_level_ff;
      in_clear_in = req_take ? req_clear_events : in_clear_ff;

      // state only moves when a tick is actually processed
      status_in = advance ? status_next : status_ff;
      count_in  = advance ? count_next : count_ff;

      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         hold_ff      <= HOLD_RESET;
         in_valid_ff  <= 1'b0;
         status_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         hold_ff      <= hold_in;
         in_valid_ff  <= in_valid_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
      in_clear_ff <= in_clear_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_pressed    = rsp_ff.is_pressed;
   assign rsp_is_held       = rsp_ff.is_held;
   assign rsp_press_event   = rsp_ff.press_event;
   assign rsp_hold_event    = rsp_ff.hold_event;
   assign rsp_release_event = rsp_ff.release_event;

`ifndef SYNTHESIS
   // stored state always has the edge tracker caught up with the pressed bit
   a_was_tracks: assert property (@(posedge clock) disable iff (reset)
      status_ff.was_pressed == status_ff.pressed)
      else $error("previous-pressed flag out of step with pressed flag");

   // held only during a press
   a_held_pressed: assert property (@(posedge clock) disable iff (reset)
      status_ff.held |-> status_ff.pressed)
      else $error("held flag set while not pressed");

   // a pending release event never survives a new press
   a_release_unpressed: assert property (@(posedge clock) disable iff (reset)
      status_ff.ev_release |-> !status_ff.pressed)
      else $error("release event pending while pressed");

   // a press edge restarts the time-since-change counter
   a_press_restarts: assert property (@(posedge clock) disable iff (reset)
      $rose(status_ff.pressed) |-> (count_ff == '0))
      else $error("counter not restarted on press");

   // state only changes when a tick passes through the update logic
   a_state_on_advance: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(status_ff) && $stable(count_ff))
      else $error("state changed without a processed request");
`endif

endmodule
